// File: hdl/keyed_wait_list_coalescer_assert.svh
// Assertion macros for the keyed wait list coalescer.
// No dependencies; included by modules that carry assertions.
`ifndef KEYED_WAIT_LIST_COALESCER_ASSERT_SVH
`define KEYED_WAIT_LIST_COALESCER_ASSERT_SVH

// Same-cycle implication or plain condition, disabled in reset.
`define KWLC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold on the cycle after the antecedent.
`define KWLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/kwlc_pkg.sv
// Package for the keyed wait list coalescer: defaults, codes and the
// controller/datapath command and status structs. No dependencies.
package kwlc_pkg;

  localparam int unsigned KEY_ENTRIES_DEF     = 8;
  localparam int unsigned WAITERS_PER_KEY_DEF = 8;
  localparam int unsigned KEY_WIDTH_DEF       = 32;
  localparam int unsigned TOKEN_WIDTH_DEF     = 32;

  localparam int unsigned CFG_W = 4;
  localparam logic [CFG_W-1:0] MAX_WAITERS_RST = 4'd8;

  localparam logic [1:0] REQ_ACQUIRE = 2'd0;
  localparam logic [1:0] REQ_DRAIN   = 2'd1;
  localparam logic [1:0] REQ_FLUSH   = 2'd2;

  typedef enum logic [2:0] {
    ST_OWNER         = 3'd0,
    ST_PARKED        = 3'd1,
    ST_FULL          = 3'd2,
    ST_TABLE_FULL    = 3'd3,
    ST_RELEASED      = 3'd4,
    ST_RELEASED_NONE = 3'd5,
    ST_NOT_FOUND     = 3'd6
  } status_e;

  typedef struct packed {
    logic    capture;
    logic    alloc;
    logic    park;
    logic    emit;
    status_e code;
    logic    key_out;
    logic    free_hit;
    logic    drain_start;
    logic    scan_start;
    logic    scan_next;
    logic    rd_issue;
    logic    rd_last;
    logic    free_cur;
    logic    clear_all;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       hit;
    logic       any_free;
    logic       hit_cnt_zero;
    logic       at_cap;
    logic       any_ne;
    logic       cur_ne;
    logic       later_ne;
    logic       j_last;
  } sts_t;

endpackage

// File: hdl/kwlc_dp.sv
// Datapath of the keyed wait list coalescer: key table, waiter store,
// walk pointers and result registers. Depends on kwlc_pkg and the assert header.
`include "keyed_wait_list_coalescer_assert.svh"

module kwlc_dp import kwlc_pkg::*; #(
  parameter int unsigned KEY_ENTRIES     = KEY_ENTRIES_DEF,
  parameter int unsigned WAITERS_PER_KEY = WAITERS_PER_KEY_DEF,
  parameter int unsigned KEY_WIDTH       = KEY_WIDTH_DEF,
  parameter int unsigned TOKEN_WIDTH     = TOKEN_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             req_type_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [TOKEN_WIDTH-1:0] waiter_token_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  output logic                   res_valid_o,
  output logic [2:0]             status_o,
  output logic [TOKEN_WIDTH-1:0] released_token_o,
  output logic [KEY_WIDTH-1:0]   released_key_o,
  output logic                   last_o
);

  localparam int unsigned DEPTH = KEY_ENTRIES * WAITERS_PER_KEY;
  localparam int unsigned KIW = (KEY_ENTRIES > 1) ? $clog2(KEY_ENTRIES) : 1;
  localparam int unsigned WIW = (WAITERS_PER_KEY > 1) ? $clog2(WAITERS_PER_KEY) : 1;
  localparam int unsigned CW  = $clog2(WAITERS_PER_KEY + 1);
  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [1:0]             req_type_q;
  logic [KEY_WIDTH-1:0]   req_key_q;
  logic [TOKEN_WIDTH-1:0] req_tok_q;
  logic [CFG_W-1:0]       max_q;

  logic [KEY_ENTRIES-1:0] valid_q;
  logic [KEY_WIDTH-1:0]   ekey_q [KEY_ENTRIES];
  logic [CW-1:0]          cnt_q  [KEY_ENTRIES];
  logic [TOKEN_WIDTH-1:0] store_q [DEPTH];

  logic [KIW-1:0] e_q;
  logic [WIW-1:0] j_q;
  logic [AW-1:0]  base_q;

  logic                   res_valid_q;
  status_e                status_q;
  logic [KEY_WIDTH-1:0]   out_key_q;
  logic                   last_q;
  logic [TOKEN_WIDTH-1:0] rd_q;

  logic [KEY_ENTRIES-1:0] match;
  logic [KEY_ENTRIES-1:0] cnt_nz;
  logic [KEY_ENTRIES-1:0] ne;
  logic                   hit;
  logic [KIW-1:0]         hit_idx;
  logic [KIW-1:0]         free_idx;
  logic                   later_ne;
  logic [CW-1:0]          hit_cnt;
  logic [CW-1:0]          cap;
  logic                   at_cap;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          rd_addr;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    later_ne = 1'b0;
    for (int i = KEY_ENTRIES - 1; i >= 0; i--) begin
      match[i]  = valid_q[i] && (ekey_q[i] == req_key_q);
      cnt_nz[i] = (cnt_q[i] != '0);
      ne[i]     = valid_q[i] && cnt_nz[i];
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = KIW'(i);
      end
      if (!valid_q[i]) begin
        free_idx = KIW'(i);
      end
    end
    for (int i = 0; i < KEY_ENTRIES; i++) begin
      if ((i > int'(e_q)) && ne[i]) begin
        later_ne = 1'b1;
      end
    end
  end

  always_comb begin
    if ({4'b0, max_q} > 8'(WAITERS_PER_KEY)) begin
      cap = CW'(WAITERS_PER_KEY);
    end else begin
      cap = CW'(max_q);
    end
  end

  assign hit_cnt = cnt_q[hit_idx];
  assign at_cap  = (hit_cnt >= cap);
  assign wr_addr = AW'(hit_idx) * AW'(WAITERS_PER_KEY) + AW'(hit_cnt);
  assign rd_addr = base_q + AW'(j_q);

  assign sts_o.req_type     = req_type_q;
  assign sts_o.hit          = hit;
  assign sts_o.any_free     = ~&valid_q;
  assign sts_o.hit_cnt_zero = (hit_cnt == '0);
  assign sts_o.at_cap       = at_cap;
  assign sts_o.any_ne       = |ne;
  assign sts_o.cur_ne       = ne[e_q];
  assign sts_o.later_ne     = later_ne;
  assign sts_o.j_last       = ((CW+1)'(j_q) + (CW+1)'(1)) == (CW+1)'(cnt_q[e_q]);

  // request capture and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_WAITERS_RST;
    end else if (cfg_we_i) begin
      max_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_type_q <= req_type_i;
      req_key_q  <= key_i;
      req_tok_q  <= waiter_token_i;
    end
  end

  // key table control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < KEY_ENTRIES; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cmd_i.alloc) begin
        valid_q[free_idx] <= 1'b1;
        cnt_q[free_idx]   <= '0;
      end
      if (cmd_i.park) begin
        cnt_q[hit_idx] <= hit_cnt + CW'(1);
      end
      if (cmd_i.free_hit) begin
        valid_q[hit_idx] <= 1'b0;
        cnt_q[hit_idx]   <= '0;
      end
      if (cmd_i.free_cur) begin
        valid_q[e_q] <= 1'b0;
        cnt_q[e_q]   <= '0;
      end
      if (cmd_i.clear_all) begin
        valid_q <= '0;
        for (int i = 0; i < KEY_ENTRIES; i++) begin
          cnt_q[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      ekey_q[free_idx] <= req_key_q;
    end
  end

  // waiter store
  always_ff @(posedge clk_i) begin
    if (cmd_i.park) begin
      store_q[wr_addr] <= req_tok_q;
    end
    if (cmd_i.rd_issue) begin
      rd_q <= store_q[rd_addr];
    end
  end

  // walk pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q    <= '0;
      j_q    <= '0;
      base_q <= '0;
    end else if (cmd_i.drain_start) begin
      e_q    <= hit_idx;
      j_q    <= '0;
      base_q <= AW'(hit_idx) * AW'(WAITERS_PER_KEY);
    end else if (cmd_i.scan_start) begin
      e_q    <= '0;
      j_q    <= '0;
      base_q <= '0;
    end else if (cmd_i.scan_next) begin
      e_q    <= e_q + KIW'(1);
      j_q    <= '0;
      base_q <= base_q + AW'(WAITERS_PER_KEY);
    end else if (cmd_i.rd_issue) begin
      j_q <= j_q + WIW'(1);
    end
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit || cmd_i.rd_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      status_q  <= ST_RELEASED;
      out_key_q <= ekey_q[e_q];
      last_q    <= cmd_i.rd_last;
    end else if (cmd_i.emit) begin
      status_q  <= cmd_i.code;
      out_key_q <= cmd_i.key_out ? req_key_q : '0;
      last_q    <= 1'b1;
    end
  end

  assign res_valid_o      = res_valid_q;
  assign status_o         = status_q;
  assign released_key_o   = out_key_q;
  assign last_o           = last_q;
  assign released_token_o = (status_q == ST_RELEASED) ? rd_q : '0;

  `KWLC_ASSERT(a_free_entry_empty, clk_i, rst_ni, ((cnt_nz & ~valid_q) == '0), "count on free entry")
  `KWLC_ASSERT(a_park_legal, clk_i, rst_ni, (cmd_i.park |-> (hit && !at_cap)), "park without room")
  `KWLC_ASSERT_NEXT(a_clear_all, clk_i, rst_ni, cmd_i.clear_all, (valid_q == '0), "table not cleared")

endmodule

// File: hdl/kwlc_ctrl.sv
// Controller of the keyed wait list coalescer: request sequencing and the
// drain/flush walk. Depends on kwlc_pkg.
module kwlc_ctrl import kwlc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_READ = 2'd3;

  logic [1:0] state_q, state_d;
  logic       flush;

  assign flush = (sts_i.req_type == REQ_FLUSH);
  assign busy  = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.code = ST_OWNER;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        unique case (sts_i.req_type)
          REQ_ACQUIRE: begin
            cmd_o.emit = 1'b1;
            if (!sts_i.hit) begin
              if (!sts_i.any_free) begin
                cmd_o.code = ST_TABLE_FULL;
              end else begin
                cmd_o.alloc = 1'b1;
                cmd_o.code  = ST_OWNER;
              end
            end else if (sts_i.at_cap) begin
              cmd_o.code = ST_FULL;
            end else begin
              cmd_o.park = 1'b1;
              cmd_o.code = ST_PARKED;
            end
          end
          REQ_DRAIN: begin
            if (!sts_i.hit) begin
              cmd_o.emit = 1'b1;
              cmd_o.code = ST_NOT_FOUND;
            end else if (sts_i.hit_cnt_zero) begin
              cmd_o.emit     = 1'b1;
              cmd_o.code     = ST_RELEASED_NONE;
              cmd_o.key_out  = 1'b1;
              cmd_o.free_hit = 1'b1;
            end else begin
              cmd_o.drain_start = 1'b1;
              state_d = S_READ;
            end
          end
          REQ_FLUSH: begin
            if (!sts_i.any_ne) begin
              cmd_o.emit      = 1'b1;
              cmd_o.code      = ST_RELEASED_NONE;
              cmd_o.clear_all = 1'b1;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d = S_SCAN;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (sts_i.cur_ne) begin
          state_d = S_READ;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        if (sts_i.j_last) begin
          if (flush) begin
            cmd_o.rd_last = !sts_i.later_ne;
            if (sts_i.later_ne) begin
              cmd_o.scan_next = 1'b1;
              state_d = S_SCAN;
            end else begin
              cmd_o.clear_all = 1'b1;
              state_d = S_IDLE;
            end
          end else begin
            cmd_o.rd_last  = 1'b1;
            cmd_o.free_cur = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/keyed_wait_list_coalescer.sv
// Keyed wait list coalescer top level: acquire/drain/flush requests, result per cycle.
// Acquire, a missing drain and an empty flush: one registered result after the EXEC state; a
// new request is taken once busy is low. A drain of n tokens gives n results back to back,
// one store read each; a flush passes through the SCAN state for every entry walked.
// Reset clears valid bits, wait counts and sets the cap to 8; the waiter store is not cleared.
module keyed_wait_list_coalescer import kwlc_pkg::*; #(
  parameter int unsigned KEY_ENTRIES     = KEY_ENTRIES_DEF,
  parameter int unsigned WAITERS_PER_KEY = WAITERS_PER_KEY_DEF,
  parameter int unsigned KEY_WIDTH       = KEY_WIDTH_DEF,
  parameter int unsigned TOKEN_WIDTH     = TOKEN_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             req_type_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [TOKEN_WIDTH-1:0] waiter_token_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_W-1:0]       cfg_data_i,
  output logic                   res_valid_o,
  output logic [2:0]             status_o,
  output logic [TOKEN_WIDTH-1:0] released_token_o,
  output logic [KEY_WIDTH-1:0]   released_key_o,
  output logic                   last_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  kwlc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  kwlc_dp #(
    .KEY_ENTRIES     (KEY_ENTRIES),
    .WAITERS_PER_KEY (WAITERS_PER_KEY),
    .KEY_WIDTH       (KEY_WIDTH),
    .TOKEN_WIDTH     (TOKEN_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_type_i       (req_type_i),
    .key_i            (key_i),
    .waiter_token_i   (waiter_token_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .res_valid_o      (res_valid_o),
    .status_o         (status_o),
    .released_token_o (released_token_o),
    .released_key_o   (released_key_o),
    .last_o           (last_o)
  );

endmodule
